@@ rtl/core/jalali_to_gregorian_date_assert.svh @@
// Assertion macros for the Jalali to Gregorian date converter.
// Each macro expects clk and rst_n in the scope where it is used.
// Defining SYNTH leaves the macros with empty bodies.
`ifndef JALALI_TO_GREGORIAN_DATE_ASSERT_SVH
`define JALALI_TO_GREGORIAN_DATE_ASSERT_SVH

`ifndef SYNTH
`define J2G_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define J2G_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define J2G_ASSERT(label, prop, msg)
`define J2G_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/j2g_pkg.sv @@
// Shared constants and helper functions for the Jalali to Gregorian converter.
// No dependencies; used by the month finder and the top level.
`timescale 1ns / 1ps

package j2g_pkg;

    localparam int unsigned STAGES     = 13;

    localparam int unsigned JY_OFFSET  = 1595;
    localparam int unsigned DAY_BASE   = 355668;
    localparam int unsigned DAYS_400Y  = 146097;
    localparam int unsigned DAYS_100Y  = 36524;
    localparam int unsigned DAYS_4Y    = 1461;
    localparam int unsigned DAYS_YEAR  = 365;
    localparam int unsigned FIRST_HALF = 186;
    localparam int unsigned CYCLE_33   = 33;

    // Reciprocal estimates: K is the dividend width, so the estimate is
    // the true quotient or one below it.
    localparam int unsigned DIV33_K    = 13;
    localparam int unsigned DIV33_M    = (1 << DIV33_K) / CYCLE_33;
    localparam int unsigned DIV400_K   = 21;
    localparam int unsigned DIV400_M   = (1 << DIV400_K) / DAYS_400Y;
    localparam int unsigned DIV100_K   = 18;
    localparam int unsigned DIV100_M   = (1 << DIV100_K) / DAYS_100Y;
    localparam int unsigned DIV4_K     = 16;
    localparam int unsigned DIV4_M     = (1 << DIV4_K) / DAYS_4Y;

    // Day offset of the first day of a Jalali month, minus one day.
    function automatic logic signed [9:0] month_offset(input logic [3:0] jm);
        int v;
        if (jm < 4'd7)
            v = (int'(jm) - 1) * 31;
        else
            v = (int'(jm) - 7) * 30 + int'(FIRST_HALF);
        return 10'(v);
    endfunction

    // Days in the Gregorian year up to and including month m.
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] c;
        case (m)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd59;
            4'd3:    c = 9'd90;
            4'd4:    c = 9'd120;
            4'd5:    c = 9'd151;
            4'd6:    c = 9'd181;
            4'd7:    c = 9'd212;
            4'd8:    c = 9'd243;
            4'd9:    c = 9'd273;
            4'd10:   c = 9'd304;
            4'd11:   c = 9'd334;
            default: c = 9'd365;
        endcase
        if (leap && m >= 4'd2)
            c = c + 9'd1;
        return c;
    endfunction

endpackage

@@ rtl/core/j2g_if.sv @@
// Valid/ready channel interfaces for Jalali dates in and Gregorian dates out.
// Stand-alone; widths follow the date field definitions.
`timescale 1ns / 1ps

interface j2g_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] persian_year;
    logic [3:0]  persian_month;
    logic [4:0]  persian_day;

    modport source (output valid, output persian_year, output persian_month,
                    output persian_day, input ready);
    modport sink   (input valid, input persian_year, input persian_month,
                    input persian_day, output ready);
endinterface

interface j2g_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] gregorian_year;
    logic [3:0]  gregorian_month;
    logic [4:0]  gregorian_day;

    modport source (output valid, output gregorian_year, output gregorian_month,
                    output gregorian_day, input ready);
    modport sink   (input valid, input gregorian_year, input gregorian_month,
                    input gregorian_day, output ready);
endinterface

@@ rtl/core/j2g_month_find.sv @@
// Month search: splits a 1-based day of year into month and day of month.
// Depends on j2g_pkg for the cumulative month length table.
`timescale 1ns / 1ps

module j2g_month_find (
    input  logic [8:0] day_of_year,
    input  logic       leap,
    output logic [3:0] month,
    output logic [4:0] mday
);

    logic [8:0] base;

    // Smallest month whose cumulative length covers the day; 13 if none.
    always_comb
    begin
        month = 4'd13;
        base  = j2g_pkg::cum_days(4'd12, leap);
        for (int k = 12; k >= 1; k--)
        begin
            if (day_of_year <= j2g_pkg::cum_days(4'(k), leap))
            begin
                month = 4'(k);
                base  = j2g_pkg::cum_days(4'(k - 1), leap);
            end
        end
        mday = 5'(day_of_year - base);
    end

endmodule

@@ rtl/core/jalali_to_gregorian_date.sv @@
// Jalali to Gregorian date converter, 13-stage pipeline.
// An accepted transaction passes through the stage registers A to M before its result is on the output.
// Throughput: one transaction per cycle while the output is ready; stages advance independently, so
// bubbles close up under backpressure and a full pipeline stalls intact.
// Reset clears only the stage valid bits; data registers are not reset.
// Depends on j2g_pkg, j2g_if, j2g_month_find and the assertion header.
`timescale 1ns / 1ps

`include "jalali_to_gregorian_date_assert.svh"

module jalali_to_gregorian_date (
    input  logic      clk,
    input  logic      rst_n,
    j2g_in_if.sink    jalali,
    j2g_out_if.source gregorian
);

    localparam int unsigned NS = j2g_pkg::STAGES;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] adv;

    // Stage A
    logic [12:0]        jy_a_reg, jy_a_next;
    logic signed [9:0]  md_a_reg, md_a_next;
    // Stage B
    logic [12:0]        jy_b_reg, jy_b_next;
    logic [7:0]         q33e_b_reg, q33e_b_next;
    logic signed [9:0]  md_b_reg, md_b_next;
    logic [20:0]        p33;
    // Stage C
    logic [12:0]        jy_c_reg, jy_c_next;
    logic signed [11:0] t_c_reg, t_c_next;
    logic [12:0]        r33_full;
    logic [6:0]         r33_0;
    logic [7:0]         q33;
    logic [5:0]         r33;
    logic [3:0]         lt;
    // Stage D
    logic [20:0]        days_d_reg, days_d_next;
    logic [22:0]        jy365;
    // Stage E
    logic [20:0]        days_e_reg, days_e_next;
    logic [3:0]         q400e_e_reg, q400e_e_next;
    logic [24:0]        p400;
    // Stage F
    logic [3:0]         q400_f_reg, q400_f_next;
    logic [17:0]        r400_f_reg, r400_f_next;
    logic [20:0]        r400_full;
    logic [18:0]        r400_0;
    // Stage G
    logic [3:0]         q400_g_reg, q400_g_next;
    logic               cent_g_reg, cent_g_next;
    logic [17:0]        t_g_reg, t_g_next;
    logic [1:0]         q100e_g_reg, q100e_g_next;
    logic [20:0]        p100;
    // Stage H
    logic [3:0]         q400_h_reg, q400_h_next;
    logic [1:0]         q100_h_reg, q100_h_next;
    logic [15:0]        r_h_reg, r_h_next;
    logic [17:0]        r100_full;
    logic [16:0]        r100_0;
    logic [15:0]        r100;
    logic [1:0]         q100c;
    // Stage I
    logic [3:0]         q400_i_reg, q400_i_next;
    logic [1:0]         q100_i_reg, q100_i_next;
    logic [15:0]        r_i_reg, r_i_next;
    logic [4:0]         q4e_i_reg, q4e_i_next;
    logic [21:0]        p4;
    // Stage J
    logic [3:0]         q400_j_reg, q400_j_next;
    logic [1:0]         q100_j_reg, q100_j_next;
    logic [4:0]         q4_j_reg, q4_j_next;
    logic [10:0]        r4_j_reg, r4_j_next;
    logic [15:0]        r4_full;
    logic [11:0]        r4_0;
    // Stage K
    logic [3:0]         q400_k_reg, q400_k_next;
    logic [1:0]         q100_k_reg, q100_k_next;
    logic [4:0]         q4_k_reg, q4_k_next;
    logic [1:0]         q1_k_reg, q1_k_next;
    logic [8:0]         gd_k_reg, gd_k_next;
    logic [10:0]        u1;
    logic [10:0]        rem1;
    // Stage L
    logic [12:0]        gy_l_reg, gy_l_next;
    logic               leap_l_reg, leap_l_next;
    logic [8:0]         gd_l_reg, gd_l_next;
    // Stage M (output)
    logic [11:0]        gy_m_reg, gy_m_next;
    logic [3:0]         gm_m_reg, gm_m_next;
    logic [4:0]         gd_m_reg, gd_m_next;

    // ---------------------------------------------------------------
    // Flow control: a stage advances when it is empty or the next one does.
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || gregorian.ready;
        for (int i = NS - 2; i >= 0; i--)
            adv[i] = !v_reg[i] || adv[i+1];
        v_next[0] = jalali.valid;
        for (int i = 1; i < NS; i++)
            v_next[i] = v_reg[i-1];
    end

    assign jalali.ready    = adv[0];
    assign gregorian.valid = v_reg[NS-1];
    assign gregorian.gregorian_year  = gy_m_reg;
    assign gregorian.gregorian_month = gm_m_reg;
    assign gregorian.gregorian_day   = gd_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
                if (adv[i])
                    v_reg[i] <= v_next[i];
        end
    end

    // ---------------------------------------------------------------
    // A: year offset and month/day offset within the Jalali year
    always_comb
    begin
        jy_a_next = 13'(jalali.persian_year) + 13'(j2g_pkg::JY_OFFSET);
        md_a_next = j2g_pkg::month_offset(jalali.persian_month)
                  + $signed({5'b0, jalali.persian_day});
    end

    // B: estimate jy / 33
    always_comb
    begin
        p33         = 21'(jy_a_reg) * 21'(j2g_pkg::DIV33_M);
        q33e_b_next = 8'(p33 >> j2g_pkg::DIV33_K);
        jy_b_next   = jy_a_reg;
        md_b_next   = md_a_reg;
    end

    // C: correct the quotient, then sum the leap-day and month terms
    always_comb
    begin
        r33_full = jy_b_reg - 13'(13'(q33e_b_reg) * 13'(j2g_pkg::CYCLE_33));
        r33_0    = r33_full[6:0];
        if (r33_0 >= 7'(j2g_pkg::CYCLE_33))
        begin
            q33 = q33e_b_reg + 8'd1;
            r33 = 6'(r33_0 - 7'(j2g_pkg::CYCLE_33));
        end
        else
        begin
            q33 = q33e_b_reg;
            r33 = r33_0[5:0];
        end
        lt        = 4'((7'(r33) + 7'd3) >> 2);
        t_c_next  = $signed({1'b0, q33, 3'b000}) + $signed({8'b0, lt}) + 12'(md_b_reg);
        jy_c_next = jy_b_reg;
    end

    // D: running day count
    always_comb
    begin
        jy365       = 23'(jy_c_reg) * 23'(j2g_pkg::DAYS_YEAR);
        days_d_next = 21'(jy365 - 23'(j2g_pkg::DAY_BASE) + 23'(t_c_reg));
    end

    // E: estimate days / 146097
    always_comb
    begin
        p400         = 25'(days_d_reg) * 25'(j2g_pkg::DIV400_M);
        q400e_e_next = 4'(p400 >> j2g_pkg::DIV400_K);
        days_e_next  = days_d_reg;
    end

    // F: correct the 400-year quotient
    always_comb
    begin
        r400_full = days_e_reg - 21'(21'(q400e_e_reg) * 21'(j2g_pkg::DAYS_400Y));
        r400_0    = r400_full[18:0];
        if (r400_0 >= 19'(j2g_pkg::DAYS_400Y))
        begin
            q400_f_next = q400e_e_reg + 4'd1;
            r400_f_next = 18'(r400_0 - 19'(j2g_pkg::DAYS_400Y));
        end
        else
        begin
            q400_f_next = q400e_e_reg;
            r400_f_next = r400_0[17:0];
        end
    end

    // G: century branch, estimate the century quotient
    always_comb
    begin
        cent_g_next  = r400_f_reg > 18'(j2g_pkg::DAYS_100Y);
        t_g_next     = cent_g_next ? r400_f_reg - 18'd1 : r400_f_reg;
        p100         = 21'(t_g_next) * 21'(j2g_pkg::DIV100_M);
        q100e_g_next = 2'(p100 >> j2g_pkg::DIV100_K);
        q400_g_next  = q400_f_reg;
    end

    // H: correct the century quotient, add the skipped century leap day back
    always_comb
    begin
        r100_full = t_g_reg - 18'(18'(q100e_g_reg) * 18'(j2g_pkg::DAYS_100Y));
        r100_0    = r100_full[16:0];
        if (r100_0 >= 17'(j2g_pkg::DAYS_100Y))
        begin
            q100c = q100e_g_reg + 2'd1;
            r100  = 16'(r100_0 - 17'(j2g_pkg::DAYS_100Y));
        end
        else
        begin
            q100c = q100e_g_reg;
            r100  = r100_0[15:0];
        end
        if (cent_g_reg)
        begin
            q100_h_next = q100c;
            r_h_next    = (r100 >= 16'(j2g_pkg::DAYS_YEAR)) ? r100 + 16'd1 : r100;
        end
        else
        begin
            q100_h_next = 2'd0;
            r_h_next    = t_g_reg[15:0];
        end
        q400_h_next = q400_g_reg;
    end

    // I: estimate the 4-year quotient
    always_comb
    begin
        p4          = 22'(r_h_reg) * 22'(j2g_pkg::DIV4_M);
        q4e_i_next  = 5'(p4 >> j2g_pkg::DIV4_K);
        r_i_next    = r_h_reg;
        q400_i_next = q400_h_reg;
        q100_i_next = q100_h_reg;
    end

    // J: correct the 4-year quotient
    always_comb
    begin
        r4_full = r_i_reg - 16'(16'(q4e_i_reg) * 16'(j2g_pkg::DAYS_4Y));
        r4_0    = r4_full[11:0];
        if (r4_0 >= 12'(j2g_pkg::DAYS_4Y))
        begin
            q4_j_next = q4e_i_reg + 5'd1;
            r4_j_next = 11'(r4_0 - 12'(j2g_pkg::DAYS_4Y));
        end
        else
        begin
            q4_j_next = q4e_i_reg;
            r4_j_next = r4_0[10:0];
        end
        q400_j_next = q400_i_reg;
        q100_j_next = q100_i_reg;
    end

    // K: single years inside the 4-year block; first year holds the leap day
    always_comb
    begin
        u1   = r4_j_reg - 11'd1;
        rem1 = r4_j_reg;
        if (r4_j_reg > 11'(j2g_pkg::DAYS_YEAR))
        begin
            if (u1 >= 11'(3 * j2g_pkg::DAYS_YEAR))
            begin
                q1_k_next = 2'd3;
                rem1      = u1 - 11'(3 * j2g_pkg::DAYS_YEAR);
            end
            else if (u1 >= 11'(2 * j2g_pkg::DAYS_YEAR))
            begin
                q1_k_next = 2'd2;
                rem1      = u1 - 11'(2 * j2g_pkg::DAYS_YEAR);
            end
            else
            begin
                q1_k_next = 2'd1;
                rem1      = u1 - 11'(j2g_pkg::DAYS_YEAR);
            end
        end
        else
        begin
            q1_k_next = 2'd0;
        end
        gd_k_next   = 9'(rem1) + 9'd1;
        q400_k_next = q400_j_reg;
        q100_k_next = q100_j_reg;
        q4_k_next   = q4_j_reg;
    end

    // L: assemble the year; leap test follows from the period digits
    always_comb
    begin
        gy_l_next   = 13'(q400_k_reg) * 13'd400 + 13'(q100_k_reg) * 13'd100
                    + 13'(q4_k_reg) * 13'd4 + 13'(q1_k_reg);
        leap_l_next = (q1_k_reg == 2'd0) && ((q4_k_reg != 5'd0) || (q100_k_reg == 2'd0));
        gd_l_next   = gd_k_reg;
    end

    // M: month search into the output register
    j2g_month_find u_month (
        .day_of_year (gd_l_reg),
        .leap        (leap_l_reg),
        .month       (gm_m_next),
        .mday        (gd_m_next)
    );

    assign gy_m_next = gy_l_reg[11:0];

    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            jy_a_reg <= jy_a_next;
            md_a_reg <= md_a_next;
        end
        if (adv[1])
        begin
            jy_b_reg   <= jy_b_next;
            q33e_b_reg <= q33e_b_next;
            md_b_reg   <= md_b_next;
        end
        if (adv[2])
        begin
            jy_c_reg <= jy_c_next;
            t_c_reg  <= t_c_next;
        end
        if (adv[3])
            days_d_reg <= days_d_next;
        if (adv[4])
        begin
            days_e_reg  <= days_e_next;
            q400e_e_reg <= q400e_e_next;
        end
        if (adv[5])
        begin
            q400_f_reg <= q400_f_next;
            r400_f_reg <= r400_f_next;
        end
        if (adv[6])
        begin
            q400_g_reg  <= q400_g_next;
            cent_g_reg  <= cent_g_next;
            t_g_reg     <= t_g_next;
            q100e_g_reg <= q100e_g_next;
        end
        if (adv[7])
        begin
            q400_h_reg <= q400_h_next;
            q100_h_reg <= q100_h_next;
            r_h_reg    <= r_h_next;
        end
        if (adv[8])
        begin
            q400_i_reg <= q400_i_next;
            q100_i_reg <= q100_i_next;
            r_i_reg    <= r_i_next;
            q4e_i_reg  <= q4e_i_next;
        end
        if (adv[9])
        begin
            q400_j_reg <= q400_j_next;
            q100_j_reg <= q100_j_next;
            q4_j_reg   <= q4_j_next;
            r4_j_reg   <= r4_j_next;
        end
        if (adv[10])
        begin
            q400_k_reg <= q400_k_next;
            q100_k_reg <= q100_k_next;
            q4_k_reg   <= q4_k_next;
            q1_k_reg   <= q1_k_next;
            gd_k_reg   <= gd_k_next;
        end
        if (adv[11])
        begin
            gy_l_reg   <= gy_l_next;
            leap_l_reg <= leap_l_next;
            gd_l_reg   <= gd_l_next;
        end
        if (adv[12])
        begin
            gy_m_reg <= gy_m_next;
            gm_m_reg <= gm_m_next;
            gd_m_reg <= gd_m_next;
        end
    end

    // ---------------------------------------------------------------
    `J2G_ASSERT(a_r400_range, !v_reg[5] || (r400_f_reg < 18'(j2g_pkg::DAYS_400Y)), "400-year remainder out of range")
    `J2G_ASSERT(a_q400_range, !v_reg[5] || (q400_f_reg <= 4'd11), "400-year quotient out of range")
    `J2G_ASSERT(a_r4_range, !v_reg[9] || (r4_j_reg < 11'(j2g_pkg::DAYS_4Y)), "4-year remainder out of range")
    `J2G_ASSERT(a_gd_range, !v_reg[10] || ((gd_k_reg != 9'd0) && (gd_k_reg <= 9'd366)), "day of year out of range")
    `J2G_ASSERT(a_stall_full, adv[0] || ((&v_reg) && !gregorian.ready), "input stalled with a free stage")
    `J2G_ASSERT_NEXT(a_drain, v_reg[NS-1] && gregorian.ready && !v_reg[NS-2], !v_reg[NS-1], "output transaction repeated")

endmodule
